// ===== rtl/assert_macros.svh =====
// assertion helpers for the view matrix checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== rtl/eyvm_pkg.sv =====
// ---------------------------------------------------------------------------
// eyvm_pkg
// types, constants and tables shared by the view matrix pipeline
// ---------------------------------------------------------------------------
package eyvm_pkg;

  localparam int AngleBits   = 16;
  localparam int CoordBits   = 32;
  localparam int UnitBits    = 16;
  localparam int CordicBits  = 34;
  localparam int PhaseBits   = 33;
  localparam int CordicSteps = 24;
  localparam int TripleBits  = 48;
  localparam int DotBits     = CoordBits + UnitBits + 2;

  localparam logic signed [CordicBits-1:0] CordicGain = CordicBits'(652032874);
  localparam logic signed [UnitBits-1:0]   UnitMax    = 16'sd16384;
  localparam logic signed [UnitBits-1:0]   UnitMin    = -16'sd16384;

  typedef struct packed {
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
    logic signed [AngleBits-1:0] rot_x;
    logic signed [AngleBits-1:0] rot_y;
    logic signed [AngleBits-1:0] rot_z;
  } pose_t;

  typedef struct packed {
    logic signed [UnitBits-1:0]  right_x;
    logic signed [UnitBits-1:0]  right_y;
    logic signed [UnitBits-1:0]  right_z;
    logic signed [UnitBits-1:0]  up_x;
    logic signed [UnitBits-1:0]  up_y;
    logic signed [UnitBits-1:0]  up_z;
    logic signed [UnitBits-1:0]  fwd_x;
    logic signed [UnitBits-1:0]  fwd_y;
    logic signed [UnitBits-1:0]  fwd_z;
    logic signed [CoordBits-1:0] trans_x;
    logic signed [CoordBits-1:0] trans_y;
    logic signed [CoordBits-1:0] trans_z;
  } view_t;

  typedef struct packed {
    logic signed [CordicBits-1:0] x;
    logic signed [CordicBits-1:0] y;
    logic signed [PhaseBits-1:0]  z;
    logic                         neg;
  } cordic_t;

  function automatic logic signed [PhaseBits-1:0] atan_phase(input int i);
    logic signed [PhaseBits-1:0] r;
    case (i)
      0: r = 33'sd536870912;   1: r = 33'sd316933406;
      2: r = 33'sd167458907;   3: r = 33'sd85004756;
      4: r = 33'sd42667331;    5: r = 33'sd21354465;
      6: r = 33'sd10679838;    7: r = 33'sd5340245;
      8: r = 33'sd2670163;     9: r = 33'sd1335087;
      10: r = 33'sd667544;     11: r = 33'sd333772;
      12: r = 33'sd166886;     13: r = 33'sd83443;
      14: r = 33'sd41722;      15: r = 33'sd20861;
      16: r = 33'sd10430;      17: r = 33'sd5215;
      18: r = 33'sd2608;       19: r = 33'sd1304;
      20: r = 33'sd652;        21: r = 33'sd326;
      22: r = 33'sd163;        23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [UnitBits-1:0] clamp_unit(
      input logic signed [TripleBits-1:0] v);
    logic signed [UnitBits-1:0] r;
    if (v > TripleBits'(UnitMax)) r = UnitMax;
    else if (v < TripleBits'(UnitMin)) r = UnitMin;
    else r = v[UnitBits-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/eyvm_cordic.sv =====
// ---------------------------------------------------------------------------
// eyvm_cordic
// pipelined rotation cordic, three angles side by side, one step per stage
// ---------------------------------------------------------------------------
module eyvm_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  eyvm_pkg::pose_t                        pose_i,
  output logic                                   valid_o,
  output eyvm_pkg::pose_t                        pose_o,
  output logic signed [2:0][eyvm_pkg::UnitBits-1:0] sin_o,
  output logic signed [2:0][eyvm_pkg::UnitBits-1:0] cos_o
);
  localparam int N = eyvm_pkg::CordicSteps;

  eyvm_pkg::cordic_t [N:0][2:0] st_q;
  eyvm_pkg::cordic_t [2:0]      st0_d;
  eyvm_pkg::pose_t   [N:0]      pose_q;
  logic              [N+1:0]    vld_q;
  logic signed [2:0][eyvm_pkg::UnitBits-1:0] sin_d, cos_d;
  logic [2:0][eyvm_pkg::AngleBits-1:0] ang;

  assign ang[0] = pose_i.rot_x;
  assign ang[1] = pose_i.rot_y;
  assign ang[2] = pose_i.rot_z;

  // fold into +-pi/2
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [31:0] ph;
      ph = {ang[k], {(32-eyvm_pkg::AngleBits){1'b0}}};
      st0_d[k].x   = eyvm_pkg::CordicGain;
      st0_d[k].y   = '0;
      st0_d[k].neg = 1'b0;
      st0_d[k].z   = eyvm_pkg::PhaseBits'(ph);
      if (ph > 32'sd1073741824) begin
        st0_d[k].z   = eyvm_pkg::PhaseBits'(ph) - 33'sd2147483648;
        st0_d[k].neg = 1'b1;
      end else if (ph < -32'sd1073741824) begin
        st0_d[k].z   = eyvm_pkg::PhaseBits'(ph) + 33'sd2147483648;
        st0_d[k].neg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0]   <= st0_d;
    pose_q[0] <= pose_i;
    for (int i = 0; i < N; i++) begin
      pose_q[i+1] <= pose_q[i];
      for (int k = 0; k < 3; k++) begin
        st_q[i+1][k].neg <= st_q[i][k].neg;
        if (!st_q[i][k].z[eyvm_pkg::PhaseBits-1]) begin
          st_q[i+1][k].x <= st_q[i][k].x - (st_q[i][k].y >>> i);
          st_q[i+1][k].y <= st_q[i][k].y + (st_q[i][k].x >>> i);
          st_q[i+1][k].z <= st_q[i][k].z - eyvm_pkg::atan_phase(i);
        end else begin
          st_q[i+1][k].x <= st_q[i][k].x + (st_q[i][k].y >>> i);
          st_q[i+1][k].y <= st_q[i][k].y - (st_q[i][k].x >>> i);
          st_q[i+1][k].z <= st_q[i][k].z + eyvm_pkg::atan_phase(i);
        end
      end
    end
  end

  // round q3.30 to q1.14, clamp, undo the fold
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [eyvm_pkg::CordicBits-1:0] rx, ry;
      logic signed [eyvm_pkg::UnitBits-1:0] cx, cy;
      rx = (st_q[N][k].x + 34'sd32768) >>> 16;
      ry = (st_q[N][k].y + 34'sd32768) >>> 16;
      cx = eyvm_pkg::clamp_unit(eyvm_pkg::TripleBits'(rx));
      cy = eyvm_pkg::clamp_unit(eyvm_pkg::TripleBits'(ry));
      cos_d[k] = st_q[N][k].neg ? -cx : cx;
      sin_d[k] = st_q[N][k].neg ? -cy : cy;
    end
  end

  always_ff @(posedge clk_i) begin
    sin_o  <= sin_d;
    cos_o  <= cos_d;
    pose_o <= pose_q[N];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N:0], valid_i};
    end
  end

  assign valid_o = vld_q[N+1];
endmodule

// ===== rtl/eyvm_basis.sv =====
// ---------------------------------------------------------------------------
// eyvm_basis
// basis vectors from sines and cosines: products, then rounded sums
// ---------------------------------------------------------------------------
module eyvm_basis (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  eyvm_pkg::pose_t                        pose_i,
  input  logic signed [2:0][eyvm_pkg::UnitBits-1:0] sin_i,
  input  logic signed [2:0][eyvm_pkg::UnitBits-1:0] cos_i,
  output logic                                   valid_o,
  output eyvm_pkg::pose_t                        pose_o,
  output logic signed [8:0][eyvm_pkg::UnitBits-1:0] m_o
);
  localparam int W = eyvm_pkg::TripleBits;
  localparam int P = 2 * eyvm_pkg::UnitBits;

  // index 0 x (pitch, s2), 1 y (yaw, s1), 2 z (roll, s3)
  logic signed [eyvm_pkg::UnitBits-1:0] s1, c1, s2, c2, s3, c3;
  assign s1 = sin_i[1]; assign c1 = cos_i[1];
  assign s2 = sin_i[0]; assign c2 = cos_i[0];
  assign s3 = sin_i[2]; assign c3 = cos_i[2];

  // stage a: two-factor products
  logic signed [P-1:0] c1c3_q, s1s2_q, c2s3_q, c1s2_q, c3s1_q, c1s3_q;
  logic signed [P-1:0] c2c3_q, c3s2_q, s1s3_q, c2s1_q, c1c2_q;
  logic signed [eyvm_pkg::UnitBits-1:0] s2a_q, s3a_q, c3a_q, nfy_q;
  eyvm_pkg::pose_t pa_q, pb_q;
  logic [1:0] vld_q;

  always_ff @(posedge clk_i) begin
    c1c3_q <= c1 * c3; s1s2_q <= s1 * s2; c2s3_q <= c2 * s3;
    c1s2_q <= c1 * s2; c3s1_q <= c3 * s1; c1s3_q <= c1 * s3;
    c2c3_q <= c2 * c3; c3s2_q <= c3 * s2; s1s3_q <= s1 * s3;
    c2s1_q <= c2 * s1; c1c2_q <= c1 * c2;
    s2a_q <= s2; s3a_q <= s3; c3a_q <= c3;
    nfy_q <= -s2;
    pa_q  <= pose_i;
  end

  function automatic logic signed [eyvm_pkg::UnitBits-1:0] q42(
      input logic signed [W-1:0] v);
    logic signed [W-1:0] t;
    t = (v + (W'(1) <<< 27)) >>> 28;
    return eyvm_pkg::clamp_unit(t);
  endfunction

  function automatic logic signed [eyvm_pkg::UnitBits-1:0] q28(
      input logic signed [P-1:0] v);
    logic signed [W-1:0] t;
    t = (W'(v) + W'(8192)) >>> 14;
    return eyvm_pkg::clamp_unit(t);
  endfunction

  // stage b: third factor and rounded sums
  always_ff @(posedge clk_i) begin
    m_o[0] <= q42((W'(c1c3_q) <<< 14) + W'(s1s2_q) * W'(s3a_q));
    m_o[1] <= q28(c2s3_q);
    m_o[2] <= q42(W'(c1s2_q) * W'(s3a_q) - (W'(c3s1_q) <<< 14));
    m_o[3] <= q42(W'(c3s1_q) * W'(s2a_q) - (W'(c1s3_q) <<< 14));
    m_o[4] <= q28(c2c3_q);
    m_o[5] <= q42(W'(c1s2_q) * W'(c3a_q) + (W'(s1s3_q) <<< 14));
    m_o[6] <= q28(c2s1_q);
    m_o[7] <= nfy_q;
    m_o[8] <= q28(c1c2_q);
    pb_q   <= pa_q;
  end

  assign pose_o = pb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end
  assign valid_o = vld_q[1];
endmodule

// ===== rtl/eyvm_translate.sv =====
// ---------------------------------------------------------------------------
// eyvm_translate
// negated dot products of basis and position, rounded and saturated
// ---------------------------------------------------------------------------
module eyvm_translate (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  eyvm_pkg::pose_t                        pose_i,
  input  logic signed [8:0][eyvm_pkg::UnitBits-1:0] m_i,
  output logic                                   valid_o,
  output eyvm_pkg::view_t                        view_o
);
  localparam int D = eyvm_pkg::DotBits;
  localparam int C = eyvm_pkg::CoordBits;
  localparam logic signed [D-1:0] TransMax = {{(D-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [D-1:0] TransMin = {{(D-C+1){1'b1}}, {(C-1){1'b0}}};

  logic signed [8:0][D-1:0] prod_q;
  logic signed [2:0][D-1:0] sum_q;
  logic signed [8:0][eyvm_pkg::UnitBits-1:0] ma_q, mb_q;
  logic signed [2:0][C-1:0] p;
  logic [2:0] vld_q;

  assign p[0] = pose_i.pos_x;
  assign p[1] = pose_i.pos_y;
  assign p[2] = pose_i.pos_z;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[3*r+c] <= D'($signed(m_i[3*r+c])) * D'($signed(p[c]));
      end
      sum_q[r] <= prod_q[3*r] + prod_q[3*r+1] + prod_q[3*r+2];
    end
    ma_q <= m_i;
    mb_q <= ma_q;
  end

  logic signed [2:0][C-1:0] t_d;
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      logic signed [D-1:0] t;
      t = -(($signed(sum_q[r]) + D'(8192)) >>> 14);
      if (t > TransMax) t_d[r] = TransMax[C-1:0];
      else if (t < TransMin) t_d[r] = TransMin[C-1:0];
      else t_d[r] = t[C-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    view_o.right_x <= mb_q[0]; view_o.right_y <= mb_q[1]; view_o.right_z <= mb_q[2];
    view_o.up_x    <= mb_q[3]; view_o.up_y    <= mb_q[4]; view_o.up_z    <= mb_q[5];
    view_o.fwd_x   <= mb_q[6]; view_o.fwd_y   <= mb_q[7]; view_o.fwd_z   <= mb_q[8];
    view_o.trans_x <= t_d[0];  view_o.trans_y <= t_d[1];  view_o.trans_z <= t_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end
  assign valid_o = vld_q[2];
endmodule

// ===== rtl/euler_yxz_view_matrix.sv =====
// ---------------------------------------------------------------------------
// euler_yxz_view_matrix
// camera pose (position, yxz euler angles) to world-to-camera view matrix
// ---------------------------------------------------------------------------
//  channel   | ports                    | transfer when
//  ----------+--------------------------+------------------------------
//  pose in   | start_i, busy_o, pose_i  | start_i high, busy_o low
//  view out  | done_o, view_o           | done_o high, one cycle only
//
//  one pose per cycle, fully pipelined; busy_o stays low
//  pipeline registers in order: fold, 24 cordic steps, rounding, two basis
//  stages, products, sums and saturation
//  reset clears only the valid bits along the pipeline
//  the receiver cannot stall, so no hold or skid is needed
// ---------------------------------------------------------------------------
module euler_yxz_view_matrix (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  eyvm_pkg::pose_t pose_i,
  output logic            done_o,
  output eyvm_pkg::view_t view_o
);
  logic cv, bv;
  eyvm_pkg::pose_t cp, bp;
  logic signed [2:0][eyvm_pkg::UnitBits-1:0] sn, cs;
  logic signed [8:0][eyvm_pkg::UnitBits-1:0] m;

  // pipeline never stalls
  assign busy_o = 1'b0;

  // sine and cosine of all three angles
  eyvm_cordic u_cordic (
    .clk_i, .rst_ni, .valid_i(start_i), .pose_i,
    .valid_o(cv), .pose_o(cp), .sin_o(sn), .cos_o(cs)
  );

  // rotation entries
  eyvm_basis u_basis (
    .clk_i, .rst_ni, .valid_i(cv), .pose_i(cp), .sin_i(sn), .cos_i(cs),
    .valid_o(bv), .pose_o(bp), .m_o(m)
  );

  // translation terms
  eyvm_translate u_trans (
    .clk_i, .rst_ni, .valid_i(bv), .pose_i(bp), .m_i(m),
    .valid_o(done_o), .view_o
  );
endmodule

// ===== rtl/eyvm_checker.sv =====
// ---------------------------------------------------------------------------
// eyvm_checker
// port-level checks on the view matrix block
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module eyvm_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start_i,
  input logic            busy_o,
  input logic            done_o,
  input eyvm_pkg::view_t view_o
);
  `ASSERT_ALWAYS(a_no_busy, clk_i, !busy_o, "busy raised")
  `ASSERT_CLK(a_latency, clk_i, rst_ni, (start_i ##31 1'b1) |-> done_o, "result missing")
  `ASSERT_CLK(a_fwd_unit, clk_i, rst_ni,
    done_o |-> (view_o.fwd_y <= 16'sd16384 && view_o.fwd_y >= -16'sd16384), "fwd_y range")
  `ASSERT_CLK(a_up_unit, clk_i, rst_ni,
    done_o |-> (view_o.up_y <= 16'sd16384 && view_o.up_y >= -16'sd16384), "up_y range")
endmodule

bind euler_yxz_view_matrix eyvm_checker u_eyvm_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .view_o
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// streams camera poses into the view matrix pipeline and checks every view
// against a cycle-free predictor of the cordic, basis and translation maths
// ---------------------------------------------------------------------------
module testbench;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 40;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start_i = 1'b0;
  logic  busy_o;
  eyvm_pkg::pose_t pose_i = '0;
  logic  done_o;
  eyvm_pkg::view_t view_o;

  eyvm_pkg::view_t expected_views[$];
  int    fail_count = 0;
  int    idle_pct = 7;
  int    quiet_cycles = 0;

  euler_yxz_view_matrix dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .pose_i(pose_i), .done_o(done_o), .view_o(view_o)
  );

  always #2 clk_i = ~clk_i;

  // arctangent table in 32-bit phase units (full turn is 2^32)
  function automatic longint atan_step(input int i);
    longint tbl[24];
    tbl = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
            10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
            83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return tbl[i];
  endfunction

  function automatic longint lim(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // sine and cosine of a binary angle, rounded to q1.14
  function automatic void angle_sin_cos(input logic [15:0] ang, output longint s,
                                        output longint c);
    longint x, y, z, dx, dy;
    bit     flip;
    x = 652032874; y = 0; flip = 0;
    z = longint'($signed({ang, 16'h0}));
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      // >>> on signed longint floors, as the hardware shifter does
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = lim((x + 32768) >>> 16, -16384, 16384);
    s = lim((y + 32768) >>> 16, -16384, 16384);
    if (flip) begin
      c = -c; s = -s;
    end
  endfunction

  function automatic longint from_q42(input longint v);
    return lim((v + (64'sd1 <<< 27)) >>> 28, -16384, 16384);
  endfunction

  function automatic longint from_q28(input longint v);
    return lim((v + 8192) >>> 14, -16384, 16384);
  endfunction

  function automatic longint neg_dot(input longint b0, b1, b2, input eyvm_pkg::pose_t p);
    longint acc;
    acc = b0 * longint'(p.pos_x) + b1 * longint'(p.pos_y) + b2 * longint'(p.pos_z);
    return lim(-((acc + 8192) >>> 14), -64'sd2147483648, 64'sd2147483647);
  endfunction

  // yaw is s1/c1, pitch s2/c2, roll s3/c3
  function automatic eyvm_pkg::view_t predict_view(input eyvm_pkg::pose_t p);
    longint s1, c1, s2, c2, s3, c3;
    longint m[9];
    eyvm_pkg::view_t v;
    angle_sin_cos(p.rot_x, s2, c2);
    angle_sin_cos(p.rot_y, s1, c1);
    angle_sin_cos(p.rot_z, s3, c3);
    m[0] = from_q42(c1 * c3 * 16384 + s1 * s2 * s3);
    m[1] = from_q28(c2 * s3);
    m[2] = from_q42(c1 * s2 * s3 - c3 * s1 * 16384);
    m[3] = from_q42(c3 * s1 * s2 - c1 * s3 * 16384);
    m[4] = from_q28(c2 * c3);
    m[5] = from_q42(c1 * c3 * s2 + s1 * s3 * 16384);
    m[6] = from_q28(c2 * s1);
    m[7] = -s2;
    m[8] = from_q28(c1 * c2);
    v.right_x = 16'(m[0]); v.right_y = 16'(m[1]); v.right_z = 16'(m[2]);
    v.up_x = 16'(m[3]); v.up_y = 16'(m[4]); v.up_z = 16'(m[5]);
    v.fwd_x = 16'(m[6]); v.fwd_y = 16'(m[7]); v.fwd_z = 16'(m[8]);
    v.trans_x = 32'(neg_dot(m[0], m[1], m[2], p));
    v.trans_y = 32'(neg_dot(m[3], m[4], m[5], p));
    v.trans_z = 32'(neg_dot(m[6], m[7], m[8], p));
    return v;
  endfunction

  // one pose transfer, with a random gap before it
  task automatic send_pose(input eyvm_pkg::pose_t p);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    pose_i  <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_views.push_back(predict_view(p));
  endtask

  // compare each view against the oldest prediction
  always @(posedge clk_i) begin
    eyvm_pkg::view_t e;
    if (rst_ni && done_o) begin
      if (expected_views.size() == 0) begin
        $error("view with no pose outstanding");
        fail_count++;
      end else begin
        e = expected_views.pop_front();
        if (view_o.right_x !== e.right_x) begin
          $error("right_x exp %0d got %0d", e.right_x, view_o.right_x); fail_count++;
        end
        if (view_o.right_y !== e.right_y) begin
          $error("right_y exp %0d got %0d", e.right_y, view_o.right_y); fail_count++;
        end
        if (view_o.right_z !== e.right_z) begin
          $error("right_z exp %0d got %0d", e.right_z, view_o.right_z); fail_count++;
        end
        if (view_o.up_x !== e.up_x) begin
          $error("up_x exp %0d got %0d", e.up_x, view_o.up_x); fail_count++;
        end
        if (view_o.up_y !== e.up_y) begin
          $error("up_y exp %0d got %0d", e.up_y, view_o.up_y); fail_count++;
        end
        if (view_o.up_z !== e.up_z) begin
          $error("up_z exp %0d got %0d", e.up_z, view_o.up_z); fail_count++;
        end
        if (view_o.fwd_x !== e.fwd_x) begin
          $error("fwd_x exp %0d got %0d", e.fwd_x, view_o.fwd_x); fail_count++;
        end
        if (view_o.fwd_y !== e.fwd_y) begin
          $error("fwd_y exp %0d got %0d", e.fwd_y, view_o.fwd_y); fail_count++;
        end
        if (view_o.fwd_z !== e.fwd_z) begin
          $error("fwd_z exp %0d got %0d", e.fwd_z, view_o.fwd_z); fail_count++;
        end
        if (view_o.trans_x !== e.trans_x) begin
          $error("trans_x exp %0d got %0d", e.trans_x, view_o.trans_x); fail_count++;
        end
        if (view_o.trans_y !== e.trans_y) begin
          $error("trans_y exp %0d got %0d", e.trans_y, view_o.trans_y); fail_count++;
        end
        if (view_o.trans_z !== e.trans_z) begin
          $error("trans_z exp %0d got %0d", e.trans_z, view_o.trans_z); fail_count++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer in either direction
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchdogLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic eyvm_pkg::pose_t make_pose(input logic [31:0] px, py, pz,
                                                input logic [15:0] ax, ay, az);
    eyvm_pkg::pose_t p;
    p.pos_x = px; p.pos_y = py; p.pos_z = pz;
    p.rot_x = ax; p.rot_y = ay; p.rot_z = az;
    return p;
  endfunction

  // angles at pi, +-pi/2, quadrant edges and extremes; positions at extremes
  // so that translation saturates
  task automatic test_corner_poses();
    logic [15:0] angs[8];
    logic [31:0] poss[5];
    angs = '{16'h0000, 16'h8000, 16'h4000, 16'hC000, 16'h7FFF, 16'h4001,
             16'hBFFF, 16'h0001};
    poss = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 32'hFFFFFFFF};
    for (int i = 0; i < 8; i++)
      send_pose(make_pose(poss[i % 5], poss[(i + 1) % 5], poss[(i + 2) % 5],
                          angs[i], angs[(i + 3) % 8], angs[(i + 5) % 8]));
    send_pose(make_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        16'h0000, 16'h0000, 16'h0000));
    send_pose(make_pose(32'h80000000, 32'h80000000, 32'h80000000,
                        16'h0000, 16'h0000, 16'h0000));
    send_pose(make_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                        16'h8000, 16'h8000, 16'h8000));
    send_pose(make_pose(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                        16'h2000, 16'hE000, 16'h6000));
  endtask

  // random poses, mostly small positions with some full range
  task automatic test_random_poses(input int count);
    eyvm_pkg::pose_t p;
    for (int n = 0; n < count; n++) begin
      idle_pct = (n >= 600 && n < 900) ? 0 : 7;
      p = make_pose($urandom, $urandom, $urandom,
                    16'($urandom), 16'($urandom), 16'($urandom));
      if ($urandom_range(3) != 0) begin
        p.pos_x = $signed(p.pos_x) >>> $urandom_range(20);
        p.pos_y = $signed(p.pos_y) >>> $urandom_range(20);
        p.pos_z = $signed(p.pos_z) >>> $urandom_range(20);
      end
      send_pose(p);
    end
  endtask

  initial begin
    int waited;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_poses();
    test_random_poses(1690);
    start_i <= 1'b0;
    waited = 0;
    while (expected_views.size() != 0 && waited < WatchdogLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_views.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/eyvm_pkg.sv
rtl/eyvm_cordic.sv
rtl/eyvm_basis.sv
rtl/eyvm_translate.sv
rtl/euler_yxz_view_matrix.sv
rtl/eyvm_checker.sv
sim/testbench.sv
